// ===== rtl/lin_frame_transmit_sequencer_core_macros.svh =====
// Assertion macros shared by the LIN frame transmit sequencer RTL.
`ifndef LIN_FRAME_TRANSMIT_SEQUENCER_CORE_MACROS_SVH
`define LIN_FRAME_TRANSMIT_SEQUENCER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define LFTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LFTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/lfts_pkg.sv =====
// Package with the types, constants and helper functions of the LIN frame sequencer.
package lfts_pkg;

    localparam int LFTS_MAX_DATA_BYTES = 8;

    localparam int LFTS_ID_W    = 6;
    localparam int LFTS_DATA_W  = 64;
    localparam int LFTS_COUNT_W = 4;
    localparam int LFTS_KIND_W  = 3;
    localparam int LFTS_BYTE_W  = 8;

    localparam logic [LFTS_BYTE_W-1:0] LFTS_SYNC_BYTE   = 8'h55;
    localparam logic [LFTS_BYTE_W-1:0] LFTS_BREAK_BYTE  = 8'h00;
    localparam logic [LFTS_ID_W-1:0]   LFTS_RESERVED_ID = 6'h3C;

    typedef enum logic [LFTS_KIND_W-1:0] {
        KIND_BREAK = 3'd0,
        KIND_SYNC  = 3'd1,
        KIND_PID   = 3'd2,
        KIND_DATA  = 3'd3,
        KIND_SUM   = 3'd4
    } t_byte_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       emit;
        t_byte_kind kind;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic empty;
        logic one;
    } t_dp_status;

    // Identifier plus its two parity bits.
    function automatic logic [LFTS_BYTE_W-1:0] make_pid(input logic [LFTS_ID_W-1:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // One's-complement byte addition: the carry wraps back into bit zero.
    function automatic logic [LFTS_BYTE_W-1:0] add_carry(input logic [LFTS_BYTE_W-1:0] a,
                                                         input logic [LFTS_BYTE_W-1:0] b);
        logic [LFTS_BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LFTS_BYTE_W-1:0] + {{(LFTS_BYTE_W-1){1'b0}}, s[LFTS_BYTE_W]};
    endfunction

endpackage

// ===== rtl/lfts_stream_if.sv =====
// Valid/ready channel interfaces for frame requests and transmitted bytes.
interface lfts_req_if import lfts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [LFTS_ID_W-1:0]    frame_id;
    logic [LFTS_DATA_W-1:0]  data_bytes;
    logic [LFTS_COUNT_W-1:0] data_count;
    logic                    classic_sum;

    modport source (output valid, frame_id, data_bytes, data_count, classic_sum,
                    input ready);
    modport sink   (input valid, frame_id, data_bytes, data_count, classic_sum,
                    output ready);
endinterface

interface lfts_byte_if import lfts_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [LFTS_KIND_W-1:0] byte_kind;
    logic [LFTS_BYTE_W-1:0] byte_value;
    logic                   last;

    modport source (output valid, byte_kind, byte_value, last, input ready);
    modport sink   (input valid, byte_kind, byte_value, last, output ready);
endinterface

// ===== rtl/lfts_ctrl.sv =====
// Frame sequencing state machine: steps through break, sync, id, any data and checksum.
module lfts_ctrl import lfts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BREAK,
        ST_SYNC,
        ST_PID,
        ST_DATA,
        ST_SUM
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   slot_free;

    // The output register can take a byte when it is empty or being drained.
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{load: 1'b0, emit: 1'b0, kind: KIND_BREAK};
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_BREAK;
                end
            end
            ST_BREAK: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_BREAK;
                    n_state    = ST_SYNC;
                end
            end
            ST_SYNC: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_SYNC;
                    n_state    = ST_PID;
                end
            end
            ST_PID: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_PID;
                    n_state    = i_status.empty ? ST_SUM : ST_DATA;
                end
            end
            ST_DATA: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_DATA;
                    n_state    = i_status.one ? ST_SUM : ST_DATA;
                end
            end
            ST_SUM: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_SUM;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/lfts_dp.sv =====
// Datapath: request capture, payload shifter, checksum accumulator and output byte register.
module lfts_dp import lfts_pkg::*; #(
    parameter int MAX_DATA_BYTES = LFTS_MAX_DATA_BYTES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  logic [LFTS_ID_W-1:0]    i_frame_id,
    input  logic [LFTS_DATA_W-1:0]  i_data_bytes,
    input  logic [LFTS_COUNT_W-1:0] i_data_count,
    input  logic                    i_classic_sum,
    output logic [LFTS_KIND_W-1:0]  o_byte_kind,
    output logic [LFTS_BYTE_W-1:0]  o_byte_value,
    output logic                    o_last
);

    localparam int SHIFT_W = LFTS_BYTE_W * MAX_DATA_BYTES;
    localparam int CNT_W   = $clog2(MAX_DATA_BYTES + 1);

    logic [SHIFT_W-1:0]     r_shift;
    logic [CNT_W-1:0]       r_left;
    logic [LFTS_BYTE_W-1:0] r_sum;
    logic [LFTS_BYTE_W-1:0] r_pid;
    logic [LFTS_KIND_W-1:0] r_kind;
    logic [LFTS_BYTE_W-1:0] r_value;
    logic                   r_last;

    logic [LFTS_BYTE_W-1:0] n_pid;
    logic [CNT_W-1:0]       n_left;
    logic [LFTS_BYTE_W-1:0] n_value;
    logic                   use_enhanced;

    assign n_pid        = make_pid(i_frame_id);
    assign use_enhanced = !i_classic_sum && (i_frame_id < LFTS_RESERVED_ID);
    assign n_left       = (i_data_count > LFTS_COUNT_W'(MAX_DATA_BYTES))
                        ? CNT_W'(MAX_DATA_BYTES) : CNT_W'(i_data_count);

    always_comb begin
        unique case (i_cmd.kind)
            KIND_BREAK: n_value = LFTS_BREAK_BYTE;
            KIND_SYNC:  n_value = LFTS_SYNC_BYTE;
            KIND_PID:   n_value = r_pid;
            KIND_DATA:  n_value = r_shift[LFTS_BYTE_W-1:0];
            KIND_SUM:   n_value = ~r_sum;
            default:    n_value = LFTS_BREAK_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_cmd.load) begin
            r_left <= n_left;
        end else if (i_cmd.emit && i_cmd.kind == KIND_DATA) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pid   <= n_pid;
            r_shift <= i_data_bytes[SHIFT_W-1:0];
            r_sum   <= use_enhanced ? n_pid : '0;
        end else if (i_cmd.emit && i_cmd.kind == KIND_DATA) begin
            r_shift <= r_shift >> LFTS_BYTE_W;
            r_sum   <= add_carry(r_sum, r_shift[LFTS_BYTE_W-1:0]);
        end
        if (i_cmd.emit) begin
            r_kind  <= i_cmd.kind;
            r_value <= n_value;
            r_last  <= (i_cmd.kind == KIND_SUM);
        end
    end

    assign o_status.empty = (r_left == '0);
    assign o_status.one   = (r_left == CNT_W'(1));
    assign o_byte_kind    = r_kind;
    assign o_byte_value   = r_value;
    assign o_last         = r_last;

endmodule

// ===== rtl/lin_frame_transmit_sequencer_core.sv =====
// LIN frame transmit sequencer: one request in, the frame's byte stream out.
// A request transfer carries a six-bit frame identifier, up to eight payload
// bytes, a byte count and the checksum style. The block answers with a stream
// of byte transfers: a break marker (value zero), the sync byte 0x55, the
// protected identifier with its two parity bits, the payload bytes with byte
// zero first, and the inverted end-around-carry checksum, which alone carries
// last. A count above MAX_DATA_BYTES is treated as MAX_DATA_BYTES. The enhanced
// checksum starts from the protected identifier; identifiers 0x3C and above
// always use the classic sum over the payload only. The idle state captures
// the request, then the state machine loads one byte per cycle into the single
// output register, so the pace is set by that register and by sink stalls. The
// next request is accepted as soon as the checksum byte has been loaded, even
// while it still waits to be taken.
`include "lin_frame_transmit_sequencer_core_macros.svh"

module lin_frame_transmit_sequencer_core import lfts_pkg::*; #(
    parameter int MAX_DATA_BYTES = LFTS_MAX_DATA_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfts_req_if.sink    i_req,
    lfts_byte_if.source o_byte
);

    // Command and status bundles between the controller and the datapath.
    t_dp_cmd    cmd;
    t_dp_status status;

    lfts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_out_ready (o_byte.ready),
        .o_out_valid (o_byte.valid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    lfts_dp #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_frame_id    (i_req.frame_id),
        .i_data_bytes  (i_req.data_bytes),
        .i_data_count  (i_req.data_count),
        .i_classic_sum (i_req.classic_sum),
        .o_byte_kind   (o_byte.byte_kind),
        .o_byte_value  (o_byte.byte_value),
        .o_last        (o_byte.last)
    );

    // A captured request keeps the block busy at least for the following cycle.
    `LFTS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "request accepted twice in a row")

    // A data byte is never produced once the byte count has run out.
    `LFTS_ASSERT_NOW(a_data_within_count, i_clk, i_rst_n, cmd.emit && cmd.kind == KIND_DATA, !status.empty, "data byte emitted beyond the byte count")

    // Capture and byte emission never coincide.
    `LFTS_ASSERT_NOW(a_load_excludes_emit, i_clk, i_rst_n, cmd.load, !cmd.emit, "request captured while a byte is emitted")

    // The end-of-frame flag goes only with the checksum byte.
    `LFTS_ASSERT_NOW(a_last_is_checksum, i_clk, i_rst_n, o_byte.valid && o_byte.last, o_byte.byte_kind == KIND_SUM, "last flag on a byte other than the checksum")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the LIN frame transmit sequencer: directed and random requests against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfts_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_FRAMES = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [LFTS_ID_W-1:0]    id;
        logic [LFTS_DATA_W-1:0]  data;
        logic [LFTS_COUNT_W-1:0] count;
        logic                    classic;
    } frame_req_t;

    typedef struct {
        t_byte_kind             kind;
        logic [LFTS_BYTE_W-1:0] value;
        logic                   last;
    } tx_byte_t;

    // Holds the bytes still owed by the frames accepted so far, oldest first.
    class frame_scoreboard;
        tx_byte_t owed_bytes[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function logic [7:0] protect_id(logic [5:0] id);
            logic p_low;
            logic p_high;
            p_low  = ^{id[4], id[2], id[1], id[0]};
            p_high = ~(^{id[5], id[4], id[3], id[1]});
            return {p_high, p_low, id};
        endfunction

        // Byte addition where the carry out re-enters at bit zero.
        static function logic [7:0] wrap_add(logic [7:0] a, logic [7:0] b);
            logic [8:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s > 9'd255)
                s = s - 9'd255;
            return s[7:0];
        endfunction

        function void note_request(frame_req_t r);
            int         n;
            logic [7:0] pid;
            logic [7:0] sum;
            logic [7:0] b;
            n   = (r.count > LFTS_MAX_DATA_BYTES) ? LFTS_MAX_DATA_BYTES : int'(r.count);
            pid = protect_id(r.id);
            // Reserved identifiers always take the classic sum.
            sum = (r.classic || r.id >= LFTS_RESERVED_ID) ? 8'h00 : pid;
            owed_bytes.push_back('{KIND_BREAK, LFTS_BREAK_BYTE, 1'b0});
            owed_bytes.push_back('{KIND_SYNC, LFTS_SYNC_BYTE, 1'b0});
            owed_bytes.push_back('{KIND_PID, pid, 1'b0});
            for (int i = 0; i < n; i++) begin
                b   = r.data[8*i +: 8];
                sum = wrap_add(sum, b);
                owed_bytes.push_back('{KIND_DATA, b, 1'b0});
            end
            owed_bytes.push_back('{KIND_SUM, ~sum, 1'b1});
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] %s", $realtime, what);
        endfunction

        function void check_byte(logic [2:0] kind, logic [7:0] value, logic last);
            tx_byte_t e;
            if (owed_bytes.size() == 0) begin
                flag($sformatf("unexpected byte: kind %0d value %02h last %0b",
                               kind, value, last));
            end else begin
                e = owed_bytes.pop_front();
                if (kind !== e.kind || value !== e.value || last !== e.last)
                    flag($sformatf("expected kind %0d value %02h last %0b, got %0d %02h %0b",
                                   e.kind, e.value, e.last, kind, value, last));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    lfts_req_if  req_if ();
    lfts_byte_if byte_if ();

    frame_scoreboard sb = new();

    int          burst_left = 1;
    int          idle_cycles = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    logic [3:0]  stall_pos = 4'd0;

    lin_frame_transmit_sequencer_core #(
        .MAX_DATA_BYTES(LFTS_MAX_DATA_BYTES)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_byte (byte_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The byte sink walks a 16-bit ready pattern and picks a new one each lap.
    always @(posedge i_clk) begin
        byte_if.ready <= stall_pat[stall_pos];
        stall_pos     <= stall_pos + 4'd1;
        if (stall_pos == 4'd15) begin
            case ($urandom_range(0, 3))
                0: stall_pat <= 16'hFFFF;
                1: stall_pat <= 16'($urandom);
                2: stall_pat <= 16'($urandom) | 16'($urandom);
                default: stall_pat <= 16'($urandom) & 16'($urandom);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && byte_if.valid && byte_if.ready)
            sb.check_byte(byte_if.byte_kind, byte_if.byte_value, byte_if.last);
    end

    // Ends the run if neither side completes a transfer for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (byte_if.valid && byte_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("lin_frame_transmit_sequencer_core: mismatch");
                $finish;
            end
        end
    end

    function automatic frame_req_t make_req(logic [5:0] id, logic [63:0] data,
                                            logic [3:0] count, logic classic);
        frame_req_t r;
        r.id      = id;
        r.data    = data;
        r.count   = count;
        r.classic = classic;
        return r;
    endfunction

    // Presents one request, waits for its transfer, then maybe closes the burst.
    task automatic issue(frame_req_t r);
        int gap;
        req_if.valid       <= 1'b1;
        req_if.frame_id    <= r.id;
        req_if.data_bytes  <= r.data;
        req_if.data_count  <= r.count;
        req_if.classic_sum <= r.classic;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
        burst_left--;
        if (burst_left <= 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        frame_req_t r;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.frame_id    <= '0;
        req_if.data_bytes  <= '0;
        req_if.data_count  <= '0;
        req_if.classic_sum <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames: field extremes, zero and saturated counts, reserved ids.
        issue(make_req(6'h00, 64'h0, 4'd0, 1'b0));
        issue(make_req(6'h00, 64'h0, 4'd0, 1'b1));
        issue(make_req(6'h3F, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0));
        issue(make_req(6'h3F, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1));
        issue(make_req(6'h3B, 64'h8877_6655_4433_2211, 4'd8, 1'b0));
        issue(make_req(6'h3C, 64'h8877_6655_4433_2211, 4'd8, 1'b0));
        issue(make_req(6'h3D, 64'h0102_0304_0506_0708, 4'd4, 1'b0));
        issue(make_req(6'h3E, 64'h0, 4'd0, 1'b0));
        issue(make_req(6'h15, 64'hA5A5_5A5A_C3C3_3C3C, 4'd9, 1'b0));
        issue(make_req(6'h2A, 64'hDEAD_BEEF_0BAD_F00D, 4'd15, 1'b1));
        issue(make_req(6'h01, 64'h0000_0000_0000_00FF, 4'd1, 1'b0));
        issue(make_req(6'h3F, 64'hFF00_FF00_FF00_FF00, 4'd12, 1'b0));
        issue(make_req(6'h10, 64'h0, 4'd8, 1'b0));
        issue(make_req(6'h20, 64'h8080_8080_8080_8080, 4'd7, 1'b0));
        issue(make_req(6'h33, 64'h7F7F_7F7F_7F7F_7F7F, 4'd8, 1'b1));
        issue(make_req(6'h0C, 64'h1234_5678_9ABC_DEF0, 4'd2, 1'b0));
        issue(make_req(6'h3C, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1));
        issue(make_req(6'h2D, 64'h0000_00FE_0000_0001, 4'd5, 1'b0));
        issue(make_req(6'h07, 64'hFEDC_BA98_7654_3210, 4'd3, 1'b1));
        issue(make_req(6'h38, 64'h0F0F_F0F0_0F0F_F0F0, 4'd6, 1'b0));

        repeat (RANDOM_FRAMES) begin
            r.id = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(58, 63)) : 6'($urandom);
            case ($urandom_range(0, 9))
                0: r.data = '1;
                1: r.data = '0;
                default: r.data = {$urandom, $urandom};
            endcase
            r.count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
            r.classic = 1'($urandom);
            issue(r);
        end

        req_if.valid <= 1'b0;
        while (sb.owed_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("lin_frame_transmit_sequencer_core: match");
        end else begin
            $display("lin_frame_transmit_sequencer_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lfts_pkg.sv
rtl/lfts_stream_if.sv
rtl/lfts_ctrl.sv
rtl/lfts_dp.sv
rtl/lin_frame_transmit_sequencer_core.sv
bench/tb_top.sv
